// ----- hdl/tbce_pkg.sv -----
// ----------------------------------------------------------------------------
// tbce_pkg
// Shared opcodes, sizes and controller/datapath handshake structs for the
// tiny byte CPU execute block.
// ----------------------------------------------------------------------------
package tbce_pkg;

  // Program window and data memory size
  localparam int PROGRAM_SLOTS = 16;
  localparam int MEMORY_DEPTH  = 256;
  localparam int LEN_W         = 5;
  localparam int EFF_W         = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Opcodes (upper nibble of the first byte)
  localparam logic [3:0] OP_LDD = 4'd0;   // Rn = M[b2]
  localparam logic [3:0] OP_STD = 4'd1;   // M[b2] = Rn
  localparam logic [3:0] OP_LDR = 4'd2;   // Rn = M[Rm]
  localparam logic [3:0] OP_STR = 4'd3;   // M[Rn] = Rm
  localparam logic [3:0] OP_LIT = 4'd4;   // Rn = b2
  localparam logic [3:0] OP_MOV = 4'd5;   // Rn = Rm
  localparam logic [3:0] OP_ADD = 4'd6;
  localparam logic [3:0] OP_SUB = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;
  localparam logic [3:0] OP_AND = 4'd10;  // sum test, equals two
  localparam logic [3:0] OP_OR  = 4'd11;  // sum test, zero / one or two
  localparam logic [3:0] OP_JZ  = 4'd12;
  localparam logic [3:0] OP_EQ  = 4'd13;
  localparam logic [3:0] OP_LT  = 4'd14;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming instruction
    logic rf_read;    // read Rn and Rm
    logic issue;      // data memory read, divider launch
    logic div_start;
    logic commit;     // write back and load the result register
  } tbce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_div;
    logic div_done;
    logic out_free;
  } tbce_sts_t;

endpackage

// ----- hdl/tbce_channels.sv -----
// ----------------------------------------------------------------------------
// tbce channels
// Valid/ready channel interfaces: instruction input, result output and
// program length configuration.
// ----------------------------------------------------------------------------
interface tbce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface

interface tbce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_pc;
  logic       done_res;
  logic       reg_write_valid;
  logic [3:0] reg_index;
  logic [7:0] reg_value;
  logic       mem_write_valid;
  logic [7:0] mem_address;
  logic [7:0] mem_value;
  modport source (output valid, output next_pc, output done_res,
                  output reg_write_valid, output reg_index, output reg_value,
                  output mem_write_valid, output mem_address, output mem_value,
                  input ready);
  modport sink   (input valid, input next_pc, input done_res,
                  input reg_write_valid, input reg_index, input reg_value,
                  input mem_write_valid, input mem_address, input mem_value,
                  output ready);
endinterface

interface tbce_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] program_length;
  modport source (output valid, output program_length, input ready);
  modport sink   (input valid, input program_length, output ready);
endinterface

// ----- hdl/tbce_div.sv -----
// ----------------------------------------------------------------------------
// tbce_div
// 8-bit restoring divider, one quotient bit per cycle. A zero divisor
// yields all ones.
// ----------------------------------------------------------------------------
module tbce_div import tbce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic [8:0] shifted;
  logic       fits;
  logic [7:0] diff;

  // One restoring step
  assign shifted = {rem_r, quo_r[7]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted[7:0] - dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = 8'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff : shifted[7:0];
      quo_nxt = {quo_r[6:0], fits};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/tbce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbce_ctrl
// Instruction sequencer: accept, register read, issue, divide wait,
// write back.
// ----------------------------------------------------------------------------
module tbce_ctrl import tbce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tbce_sts_t sts,
  output tbce_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.rf_read = 1'b1;
        state_nxt   = S_EX;
      end
      S_EX: begin
        cmd.issue = 1'b1;
        if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WB;
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/tbce_datapath.sv -----
// ----------------------------------------------------------------------------
// tbce_datapath
// Register file, data memory, ALU, divider, program counter, program
// length register and the result register.
// ----------------------------------------------------------------------------
module tbce_datapath import tbce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbce_cmd_t        cmd,
  output tbce_sts_t        sts,
  input  logic [7:0]       first_byte,
  input  logic [7:0]       second_byte,
  input  logic             cfg_valid,
  input  logic [LEN_W-1:0] cfg_length,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [7:0]       next_pc,
  output logic             done_res,
  output logic             reg_write_valid,
  output logic [3:0]       reg_index,
  output logic [7:0]       reg_value,
  output logic             mem_write_valid,
  output logic [7:0]       mem_address,
  output logic [7:0]       mem_value
);

  // Instruction latch
  logic [7:0] b1_r, b2_r;
  logic [3:0] op, rn, rm;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b1_r <= first_byte;
      b2_r <= second_byte;
    end
  end

  assign op = b1_r[7:4];
  assign rn = b1_r[3:0];
  assign rm = b2_r[7:4];

  // Control registers: pc, program length, valid bits, result valid
  logic [7:0]              pc_r, pc_nxt;
  logic [LEN_W-1:0]        len_r;
  logic [15:0]             rf_vld_r;
  logic [MEMORY_DEPTH-1:0] dm_vld_r;
  logic                    out_vld_r, out_vld_nxt;

  // Result of the current instruction
  logic       rw, mw;
  logic [7:0] rv, maddr, mv, npc;
  logic       done_c;

  // Register file: two registered reads, one write
  logic [7:0] rf_mem [16];
  logic [7:0] a_raw_r, b_raw_r;
  logic       a_vld_r, b_vld_r;
  logic [7:0] a, b;

  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      a_raw_r <= rf_mem[rn];
      b_raw_r <= rf_mem[rm];
      a_vld_r <= rf_vld_r[rn];
      b_vld_r <= rf_vld_r[rm];
    end
    if (cmd.commit && rw) rf_mem[rn] <= rv;
  end

  // Entries not yet written read as zero
  assign a = a_vld_r ? a_raw_r : 8'd0;
  assign b = b_vld_r ? b_raw_r : 8'd0;

  // Data memory: one registered read, one write
  logic [7:0] dm_mem [MEMORY_DEPTH];
  logic [7:0] ld_addr;
  logic [7:0] md_raw_r;
  logic       md_vld_r;
  logic [7:0] md;

  assign ld_addr = (op == OP_LDR) ? b : b2_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      md_raw_r <= dm_mem[ld_addr];
      md_vld_r <= dm_vld_r[ld_addr];
    end
    if (cmd.commit && mw) dm_mem[maddr] <= mv;
  end

  assign md = md_vld_r ? md_raw_r : 8'd0;

  // Divider
  logic       div_done;
  logic [7:0] quotient;

  tbce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (quotient)
  );

  // Effective program length and halt check
  logic [EFF_W-1:0] len_ext, eff_len;
  logic             halted;

  assign len_ext = {{(EFF_W-LEN_W){1'b0}}, len_r};
  assign eff_len = (len_ext > EFF_W'(PROGRAM_SLOTS)) ? EFF_W'(PROGRAM_SLOTS) : len_ext;
  assign halted  = {1'b0, pc_r} >= eff_len;

  // Execute
  logic [8:0] sum9;
  logic [7:0] prod;
  logic [7:0] base_pc;

  assign sum9 = {1'b0, a} + {1'b0, b};
  assign prod = a * b;

  always_comb begin
    rw      = 1'b0;
    mw      = 1'b0;
    rv      = 8'd0;
    maddr   = 8'd0;
    mv      = 8'd0;
    base_pc = pc_r;
    case (op)
      OP_LDD: begin rw = 1'b1; rv = md; end
      OP_STD: begin mw = 1'b1; maddr = b2_r; mv = a; end
      OP_LDR: begin rw = 1'b1; rv = md; end
      OP_STR: begin mw = 1'b1; maddr = a; mv = b; end
      OP_LIT: begin rw = 1'b1; rv = b2_r; end
      OP_MOV: begin rw = 1'b1; rv = b; end
      OP_ADD: begin rw = 1'b1; rv = sum9[7:0]; end
      OP_SUB: begin rw = 1'b1; rv = a - b; end
      OP_MUL: begin rw = 1'b1; rv = prod; end
      OP_DIV: begin rw = 1'b1; rv = quotient; end
      OP_AND: begin rw = 1'b1; rv = {7'd0, sum9 == 9'd2}; end
      OP_OR: begin
        // zero sum writes 0, sum of one or two writes 1, else no write
        if (sum9 == 9'd0) begin
          rw = 1'b1;
        end else if (sum9 < 9'd3) begin
          rw = 1'b1;
          rv = 8'd1;
        end
      end
      OP_JZ: begin
        if (a == 8'd0) base_pc = pc_r + b2_r;
      end
      OP_EQ:   begin rw = 1'b1; rv = {7'd0, a == b}; end
      OP_LT:   begin rw = 1'b1; rv = {7'd0, a < b}; end
      default: ;
    endcase
    npc = base_pc + 8'd1;
    // Past the end of the program: hold the pc, write nothing
    if (halted) begin
      rw    = 1'b0;
      mw    = 1'b0;
      rv    = 8'd0;
      maddr = 8'd0;
      mv    = 8'd0;
      npc   = pc_r;
    end
  end

  assign done_c = {1'b0, npc} >= eff_len;
  assign pc_nxt = cmd.commit ? npc : pc_r;

  // Result register handshake
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit)     out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 8'd0;
      len_r     <= LEN_RESET;
      rf_vld_r  <= '0;
      dm_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid) len_r <= cfg_length;
      if (cmd.commit && rw) rf_vld_r[rn] <= 1'b1;
      if (cmd.commit && mw) dm_vld_r[maddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_pc         <= npc;
      done_res        <= done_c;
      reg_write_valid <= rw;
      reg_index       <= rw ? rn : 4'd0;
      reg_value       <= rv;
      mem_write_valid <= mw;
      mem_address     <= maddr;
      mem_value       <= mv;
    end
  end

  assign out_valid    = out_vld_r;
  assign sts.is_div   = (op == OP_DIV);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_vld_r || out_ready;

endmodule

// ----- hdl/tiny_byte_cpu_execute_top.sv -----
// ----------------------------------------------------------------------------
// tiny_byte_cpu_execute_top
// Executes one two-byte instruction per item on an 8-bit machine with
// 16 registers and 256 data bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | first_byte, second_byte
//  out_ch  | out | next_pc, done_res, reg/mem write fields
//  cfg_ch  | in  | program_length (always ready)
//
//  One instruction at a time: accept, register read, issue, write back;
//  a divide also waits in the divide state for the bit-serial divider.
//  Reset clears pc, length (16), and valid bits of registers and memory.
//  A stalled result holds in the result register; the next item is still
//  accepted and waits in write back.
// ----------------------------------------------------------------------------
module tiny_byte_cpu_execute_top import tbce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tbce_in_if.sink     in_ch,
  tbce_out_if.source  out_ch,
  tbce_cfg_if.sink    cfg_ch
);

  tbce_cmd_t cmd;
  tbce_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // Sequencer
  tbce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  tbce_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .first_byte      (in_ch.first_byte),
    .second_byte     (in_ch.second_byte),
    .cfg_valid       (cfg_ch.valid),
    .cfg_length      (cfg_ch.program_length),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .next_pc         (out_ch.next_pc),
    .done_res        (out_ch.done_res),
    .reg_write_valid (out_ch.reg_write_valid),
    .reg_index       (out_ch.reg_index),
    .reg_value       (out_ch.reg_value),
    .mem_write_valid (out_ch.mem_write_valid),
    .mem_address     (out_ch.mem_address),
    .mem_value       (out_ch.mem_value)
  );

  // One item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  // Unused register write fields are zero
  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.reg_write_valid) |->
      (out_ch.reg_index == 4'd0 && out_ch.reg_value == 8'd0))
    else $error("register fields set without a register write");

  // Unused memory write fields are zero
  a_mem_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.mem_write_valid) |->
      (out_ch.mem_address == 8'd0 && out_ch.mem_value == 8'd0))
    else $error("memory fields set without a memory write");

  // No instruction writes both a register and memory
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.reg_write_valid && out_ch.mem_write_valid))
    else $error("register and memory written by one instruction");

endmodule

// ----- tb/sv/tbce_exec_monitor.sv -----
// ----------------------------------------------------------------------------
// tbce_exec_monitor
// Watches the instruction, result and length channels of the tiny byte CPU
// execute block, runs its own copy of the machine state on every accepted
// item and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tbce_exec_monitor import tbce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tbce_in_if         in_ch,
  tbce_out_if        out_ch,
  tbce_cfg_if        cfg_ch,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output logic [7:0] pc_state
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       done;
    logic       rw;
    logic [3:0] ridx;
    logic [7:0] rval;
    logic       mw;
    logic [7:0] maddr;
    logic [7:0] mval;
  } exec_result_t;

  // Shadow machine state
  logic [7:0]       regs [16];
  logic [7:0]       dmem [MEMORY_DEPTH];
  logic [LEN_W-1:0] prog_len;
  exec_result_t     expected_q [$];

  // Execute one instruction on the shadow state and return its result
  function automatic exec_result_t execute_instr(input logic [7:0] b1, input logic [7:0] b2);
    exec_result_t r;
    logic [3:0]   op;
    logic [3:0]   rn;
    logic [3:0]   rm;
    logic [7:0]   a;
    logic [7:0]   b;
    logic [7:0]   npc;
    logic [8:0]   sum;
    int           eff;
    r   = '0;
    op  = b1[7:4];
    rn  = b1[3:0];
    rm  = b2[7:4];
    a   = regs[rn];
    b   = regs[rm];
    sum = a + b;
    eff = (prog_len > PROGRAM_SLOTS) ? PROGRAM_SLOTS : prog_len;
    // halted: instruction dropped, pc held
    if (pc_state >= eff) begin
      r.next_pc = pc_state;
      r.done    = 1'b1;
      return r;
    end
    npc = pc_state;
    case (op)
      OP_LDD: begin r.rw = 1'b1; r.rval = dmem[b2]; end
      OP_STD: begin r.mw = 1'b1; r.maddr = b2; r.mval = a; end
      OP_LDR: begin r.rw = 1'b1; r.rval = dmem[b]; end
      OP_STR: begin r.mw = 1'b1; r.maddr = a; r.mval = b; end
      OP_LIT: begin r.rw = 1'b1; r.rval = b2; end
      OP_MOV: begin r.rw = 1'b1; r.rval = b; end
      OP_ADD: begin r.rw = 1'b1; r.rval = a + b; end
      OP_SUB: begin r.rw = 1'b1; r.rval = a - b; end
      OP_MUL: begin r.rw = 1'b1; r.rval = a * b; end
      OP_DIV: begin r.rw = 1'b1; r.rval = (b == 8'd0) ? 8'hFF : a / b; end
      // sum tests work on the full 9-bit sum
      OP_AND: begin r.rw = 1'b1; r.rval = (sum == 9'd2) ? 8'd1 : 8'd0; end
      OP_OR: begin
        if (sum == 9'd0) begin
          r.rw = 1'b1;
        end else if (sum < 9'd3) begin
          r.rw   = 1'b1;
          r.rval = 8'd1;
        end
      end
      OP_JZ: begin
        if (a == 8'd0) npc = pc_state + b2;
      end
      OP_EQ: begin r.rw = 1'b1; r.rval = (a == b) ? 8'd1 : 8'd0; end
      OP_LT: begin r.rw = 1'b1; r.rval = (a < b) ? 8'd1 : 8'd0; end
      default: ;
    endcase
    if (r.rw) begin
      r.ridx   = rn;
      regs[rn] = r.rval;
    end
    if (r.mw) dmem[r.maddr] = r.mval;
    npc       = npc + 8'd1;
    pc_state  = npc;
    r.next_pc = npc;
    r.done    = (npc >= eff);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Channel watch: length writes, then new items, then results
  always @(posedge clk) begin : watch
    exec_result_t got;
    exec_result_t want;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc_state = '0;
      prog_len = LEN_RESET;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) prog_len = cfg_ch.program_length;
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(execute_instr(in_ch.first_byte, in_ch.second_byte));
      if (out_ch.valid && out_ch.ready) begin
        got = '{next_pc: out_ch.next_pc, done: out_ch.done_res,
                rw: out_ch.reg_write_valid, ridx: out_ch.reg_index,
                rval: out_ch.reg_value, mw: out_ch.mem_write_valid,
                maddr: out_ch.mem_address, mval: out_ch.mem_value};
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with no instruction outstanding, next_pc %0d", got.next_pc);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("next_pc", want.next_pc, got.next_pc);
          compare_field("done_res", want.done, got.done);
          compare_field("reg_write_valid", want.rw, got.rw);
          compare_field("reg_index", want.ridx, got.ridx);
          compare_field("reg_value", want.rval, got.rval);
          compare_field("mem_write_valid", want.mw, got.mw);
          compare_field("mem_address", want.maddr, got.maddr);
          compare_field("mem_value", want.mval, got.mval);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction streams into the tiny byte CPU execute block: a short
// hand-written program over every opcode and corner case, then random
// programs that keep the pc inside the program window, with length changes,
// halted stretches and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tbce_pkg::*;

  localparam logic [3:0] OP_NOP    = 4'd15;
  localparam int         ITEM_GOAL = 650;
  localparam int         IDLE_PCT  = 14;
  localparam int         TAIL      = 20;
  localparam int         LIMIT     = 200000;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tbce_in_if  in_ch ();
  tbce_out_if out_ch ();
  tbce_cfg_if cfg_ch ();

  tiny_byte_cpu_execute_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int         fail_count;
  int         pending_results;
  int         results_seen;
  logic [7:0] model_pc;

  tbce_exec_monitor exec_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending_results),
    .results_seen (results_seen),
    .pc_state     (model_pc)
  );

  logic             idle_on = 1'b1;
  logic [LEN_W-1:0] cur_len = LEN_RESET;
  logic [3:0]       zero_reg;
  int               exec_count;
  int               halted_count;
  int               length_writes;
  int               cycle_count;

  function automatic int eff_len();
    return (cur_len > PROGRAM_SLOTS) ? PROGRAM_SLOTS : cur_len;
  endfunction

  // Send one instruction; called and returns at a falling edge
  task automatic send_instr(input logic [7:0] b1, input logic [7:0] b2);
    if (model_pc >= eff_len()) halted_count++;
    else exec_count++;
    @(posedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.first_byte  <= b1;
    in_ch.second_byte <= b2;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Program length write, only once every result is back
  task automatic write_length(input logic [LEN_W-1:0] len);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.program_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    cur_len = len;
    length_writes++;
  endtask

  // One random step; pc is kept below 16 so a later length change can resume
  task automatic random_step();
    logic [3:0] op;
    logic [7:0] b1;
    logic [7:0] b2;
    int         t;
    int         lim;
    if (model_pc >= eff_len()) begin
      // halted: a few dropped items, then open the window past the pc
      repeat ($urandom_range(0, 2))
        send_instr(8'($urandom_range(255)), 8'($urandom_range(255)));
      write_length(LEN_W'($urandom_range(model_pc + 1, 31)));
    end else if (model_pc == 14) begin
      // clear a register for the wrap jump at the last slot
      zero_reg = 4'($urandom_range(15));
      send_instr({OP_LIT, zero_reg}, 8'h00);
    end else if (model_pc == 15) begin
      t = $urandom_range(0, 13);
      send_instr({OP_JZ, zero_reg}, 8'(t - 16));
    end else begin
      op = 4'($urandom_range(15));
      b1 = {op, 4'($urandom_range(15))};
      b2 = 8'($urandom_range(255));
      if (op == OP_JZ) begin
        // target mostly inside the window, sometimes its end or beyond
        lim = (eff_len() < 13) ? eff_len() : 13;
        t   = $urandom_range(0, lim);
        if ($urandom_range(9) == 0) t = $urandom_range(0, 13);
        b2 = 8'(t - model_pc - 1);
      end
      send_instr(b1, b2);
    end
  endtask

  // Result side back pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [15:0] directed_prog [$];
    int          next_phase;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.first_byte      <= '0;
    in_ch.second_byte     <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.program_length <= LEN_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero length: the first instruction is dropped
    write_length(5'd0);
    send_instr({OP_LIT, 4'd1}, 8'hFF);
    write_length(5'd31);

    // hand-written program: sum tests, wrap arithmetic, divide by zero,
    // wrap jump from the last slot, then memory, moves, compares and no-op
    directed_prog = '{
      {OP_LIT, 4'd1, 8'hFF}, {OP_LIT, 4'd2, 8'h03}, {OP_AND, 4'd1, 8'h20},
      {OP_OR, 4'd2, 8'h10},  {OP_OR, 4'd1, 8'h10},  {OP_LIT, 4'd1, 8'h01},
      {OP_AND, 4'd1, 8'h10}, {OP_OR, 4'd1, 8'h00},  {OP_LIT, 4'd4, 8'hFF},
      {OP_ADD, 4'd4, 8'h20}, {OP_SUB, 4'd5, 8'h20}, {OP_MUL, 4'd5, 8'h50},
      {OP_DIV, 4'd5, 8'h00}, {OP_DIV, 4'd5, 8'h20}, {OP_LIT, 4'd6, 8'h00},
      {OP_JZ, 4'd6, 8'hF0},  {OP_STD, 4'd5, 8'hFF}, {OP_LDD, 4'd0, 8'hFF},
      {OP_STR, 4'd2, 8'h50}, {OP_LDR, 4'd8, 8'h20}, {OP_MOV, 4'd9, 8'h80},
      {OP_EQ, 4'd9, 8'h80},  {OP_LT, 4'd9, 8'h80},  {OP_NOP, 4'd15, 8'hFF}
    };
    foreach (directed_prog[i]) send_instr(directed_prog[i][15:8], directed_prog[i][7:0]);

    // random programs with occasional length changes
    next_phase = exec_count + 60;
    while (exec_count < ITEM_GOAL) begin
      idle_on = !(exec_count >= 250 && exec_count < 400);
      if (exec_count >= next_phase) begin
        write_length(LEN_W'($urandom_range(31)));
        next_phase = exec_count + 60 + $urandom_range(40);
      end
      random_step();
    end
    idle_on = 1'b1;

    while (pending_results != 0) @(negedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Executed %0d instructions and sent %0d more while halted, over %0d length writes.",
             exec_count, halted_count, length_writes);
    $display("Compared %0d results against the predicted machine state.", results_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
